// ===== rtl/dfr_pkg.sv =====
// Package for the byte-stuffed deframer with CRC-16 check.
// Holds field widths, result kind codes, register indexes and shared structs.
// Used by the interfaces and every module of the block.
`default_nettype none

package dfr_pkg;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 9;
   localparam int CRC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ABORT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OVER  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 2'd2;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'hFD;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'hFE;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [BYTE_W-1:0] escape_code;
   } codes_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type item;
   } step_out_type;

endpackage

`default_nettype wire

// ===== rtl/dfr_if.sv =====
// Valid/ready stream interfaces for the deframer's input and result channels.
// Depends on dfr_pkg for the payload widths.
`default_nettype none

interface dfr_req_if;
   logic                       valid;
   logic                       ready;
   logic [dfr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dfr_pkg::KIND_W-1:0] kind;
   logic [dfr_pkg::BYTE_W-1:0] data_byte;
   logic [dfr_pkg::LEN_W-1:0]  frame_length;

   modport source (output valid, output kind, output data_byte, output frame_length,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input frame_length,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/dfr_crc16.sv =====
// Bytewise CRC-16 update, polynomial 0x1021, no reflection.
// Depends on dfr_pkg for widths and the polynomial.
`default_nettype none

module dfr_crc16 (
   input  wire logic [dfr_pkg::CRC_W-1:0]  crc_in,
   input  wire logic [dfr_pkg::BYTE_W-1:0] data_in,
   output logic      [dfr_pkg::CRC_W-1:0]  crc_out
);
   import dfr_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] acc;
      acc = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (acc[CRC_W-1]) begin
            acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[CRC_W-2:0], 1'b0};
         end
      end
      crc_out = acc;
   end

endmodule

`default_nettype wire

// ===== rtl/dfr_frame.sv =====
// Frame state of the deframer: escape handling, two-byte hold line, CRC and length.
// Processes one byte per enabled cycle. Depends on dfr_pkg and dfr_crc16.
`default_nettype none

module dfr_frame #(
   parameter int MAX_PAYLOAD = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step_en,
   input  wire logic [dfr_pkg::BYTE_W-1:0] step_byte,
   input  wire dfr_pkg::codes_type         codes,
   output dfr_pkg::step_out_type           step_out
);
   import dfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   logic              in_frame_ff, in_frame_in;
   logic              esc_ff, esc_in;
   logic [1:0]        held_cnt_ff, held_cnt_in;
   logic [BYTE_W-1:0] held_ff [2];
   logic [BYTE_W-1:0] held_in [2];
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              over_ff, over_in;

   logic [CRC_W-1:0]         crc_next;
   logic [CNT_W+LEN_W-1:0]   count_ext;
   logic [LEN_W-1:0]         count_len;
   logic                     esc_lit;
   logic                     is_code;
   logic                     take;

   dfr_crc16 u_crc (
      .crc_in  (crc_ff),
      .data_in (held_ff[0]),
      .crc_out (crc_next)
   );

   assign count_ext = {{LEN_W{1'b0}}, count_ff};
   assign count_len = count_ext[LEN_W-1:0];
   assign esc_lit   = in_frame_ff && esc_ff;
   assign is_code   = (step_byte == codes.start_code) || (step_byte == codes.end_code) ||
                      (step_byte == codes.escape_code);

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      held_cnt_in = held_cnt_ff;
      held_in     = held_ff;
      crc_in      = crc_ff;
      count_in    = count_ff;
      over_in     = over_ff;
      take        = 1'b0;
      step_out    = '0;

      if (step_en) begin
         priority if (esc_lit) begin
            esc_in = 1'b0;
            take   = is_code;
         end else if (step_byte == codes.start_code) begin
            in_frame_in = 1'b1;
            esc_in      = 1'b0;
            held_cnt_in = '0;
            held_in[0]  = '0;
            held_in[1]  = '0;
            crc_in      = CRC_INIT;
            count_in    = '0;
            over_in     = 1'b0;
            if (in_frame_ff) begin
               step_out.valid     = 1'b1;
               step_out.item.kind = KIND_ABORT;
            end
         end else if (!in_frame_ff) begin
            take = 1'b0;
         end else if (step_byte == codes.end_code) begin
            in_frame_in    = 1'b0;
            step_out.valid = 1'b1;
            priority if (over_ff) begin
               step_out.item.kind         = KIND_OVER;
               step_out.item.frame_length = count_len;
            end else if (held_cnt_ff < 2'd2) begin
               step_out.item.kind = KIND_BAD;
            end else begin
               step_out.item.kind = ({held_ff[0], held_ff[1]} == crc_ff) ? KIND_GOOD
                                                                         : KIND_BAD;
               step_out.item.frame_length = count_len;
            end
         end else if (step_byte == codes.escape_code) begin
            esc_in = 1'b1;
         end else begin
            take = 1'b1;
         end

         if (take && !over_ff) begin
            priority if (held_cnt_ff < 2'd2) begin
               held_in[held_cnt_ff[0]] = step_byte;
               held_cnt_in             = held_cnt_ff + 2'd1;
            end else if (count_ff >= CNT_MAX) begin
               over_in = 1'b1;
            end else begin
               held_in[0]              = held_ff[1];
               held_in[1]              = step_byte;
               crc_in                  = crc_next;
               count_in                = count_ff + CNT_W'(1);
               step_out.valid          = 1'b1;
               step_out.item.kind      = KIND_DATA;
               step_out.item.data_byte = held_ff[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         held_cnt_ff <= '0;
         crc_ff      <= CRC_INIT;
         count_ff    <= '0;
         over_ff     <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         held_cnt_ff <= held_cnt_in;
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         over_ff     <= over_in;
      end
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

// ===== rtl/byte_stuffed_deframer_crc16.sv =====
// Top level of the byte-stuffed deframer with CRC-16 check.
// Holds the code registers and the input and result registers.
// Depends on dfr_pkg, dfr_if and dfr_frame.
`default_nettype none

// The block takes one received byte per item and sustains one item per clock
// cycle while the result channel is not stalled. An accepted byte passes
// through the input register and then the result register. The per-byte CRC
// update and frame decode settle combinationally between them. A byte
// outside a frame, a start byte of a first frame, an escape byte and the
// first two data bytes of a frame give no result. The code registers may be
// written only while the block is idle.
module byte_stuffed_deframer_crc16_core #(
   parameter int MAX_PAYLOAD = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dfr_req_if.sink                            req_bus,
   dfr_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [dfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dfr_pkg::BYTE_W-1:0]    csr_wdata
);
   import dfr_pkg::*;

   codes_type         codes_ff, codes_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_item_ff, out_item_in;

   step_out_type step_out;
   logic         out_free;
   logic         advance;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !reset && (!in_valid_ff || advance);

   dfr_frame #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .codes     (codes_ff),
      .step_out  (step_out)
   );

   always_comb begin
      codes_in = codes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START:  codes_in.start_code  = csr_wdata;
            CSR_END:    codes_in.end_code    = csr_wdata;
            CSR_ESCAPE: codes_in.escape_code = csr_wdata;
            default:    codes_in = codes_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.rx_byte;
      end
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = advance && step_out.valid;
         out_item_in  = step_out.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.start_code  <= START_RESET;
         codes_ff.end_code    <= END_RESET;
         codes_ff.escape_code <= ESCAPE_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         codes_ff     <= codes_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_item_ff.kind;
   assign rsp_bus.data_byte    = out_item_ff.data_byte;
   assign rsp_bus.frame_length = out_item_ff.frame_length;

endmodule

`default_nettype wire
